// ----- hdl/dpd_pkg.sv -----
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared types and constants for the delta patch decoder.
// ----------------------------------------------------------------------------
package dpd_pkg;

  // largest region the decoder may address
  localparam int unsigned REGION_MAX_BYTES = 1048576;
  localparam logic [32:0] REGION_MAX_W     = 33'(REGION_MAX_BYTES);

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 21;
  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned SHIFT_W  = 6;
  localparam int unsigned STATUS_W = 2;

  // reset value of region_bytes
  localparam logic [COUNT_W-1:0] REGION_RESET = 21'h100000;

  // varint byte layout and shift step
  localparam logic [BYTE_W-1:0]  VARINT_PAYLOAD = 8'h7F;
  localparam logic [BYTE_W-1:0]  VARINT_MORE    = 8'h80;
  localparam logic [SHIFT_W-1:0] VARINT_STEP    = 6'd7;
  localparam logic [SHIFT_W-1:0] VARINT_LIMIT   = 6'd32;

  // parse phases
  localparam logic [1:0] PH_OFFSET = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_RUN   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0]  patch_byte;
    logic [COUNT_W-1:0] stream_bytes;
  } item_t;

  typedef struct packed {
    logic                write_enable;
    logic [ADDR_W-1:0]   write_address;
    logic [BYTE_W-1:0]   write_data;
    logic [STATUS_W-1:0] status;
  } result_t;

  // parser status seen by the top level
  typedef struct packed {
    logic [STATUS_W-1:0] err;
    logic [1:0]          phase;
    logic                pos_zero;
  } parse_stat_t;

endpackage

// ----- hdl/dpd_ifs.sv -----
// ----------------------------------------------------------------------------
// dpd_ifs
// Valid/ready channel interfaces for patch bytes and write results.
// ----------------------------------------------------------------------------
interface dpd_in_if;
  logic                         valid;
  logic                         ready;
  logic [dpd_pkg::BYTE_W-1:0]   patch_byte;
  logic [dpd_pkg::COUNT_W-1:0]  stream_bytes;

  modport source (output valid, output patch_byte, output stream_bytes, input ready);
  modport sink   (input valid, input patch_byte, input stream_bytes, output ready);
endinterface

interface dpd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          write_enable;
  logic [dpd_pkg::ADDR_W-1:0]    write_address;
  logic [dpd_pkg::BYTE_W-1:0]    write_data;
  logic [dpd_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output write_enable, output write_address,
                  output write_data, output status, input ready);
  modport sink   (input valid, input write_enable, input write_address,
                  input write_data, input status, output ready);
endinterface

// ----- hdl/dpd_in_reg.sv -----
// ----------------------------------------------------------------------------
// dpd_in_reg
// Input register stage holding one patch byte transaction.
// ----------------------------------------------------------------------------
module dpd_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  dpd_pkg::item_t in_item,
  output logic           in_ready,
  input  logic           take,
  output logic           valid_r,
  output dpd_pkg::item_t item_r
);

  logic           valid_nxt;
  dpd_pkg::item_t item_nxt;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
    if (in_valid && in_ready) begin
      item_nxt = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

// ----- hdl/dpd_parse.sv -----
// ----------------------------------------------------------------------------
// dpd_parse
// Parser state and single-pass step logic: varint headers, data writes, checks.
// ----------------------------------------------------------------------------
module dpd_parse (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  dpd_pkg::item_t               item,
  input  logic [dpd_pkg::COUNT_W-1:0]  region_bytes,
  output dpd_pkg::result_t             result,
  output dpd_pkg::parse_stat_t         stat
);

  logic [1:0]                         phase_r,   phase_nxt;
  logic [dpd_pkg::ACC_W-1:0]          off_acc_r, off_acc_nxt;
  logic [dpd_pkg::ACC_W-1:0]          len_acc_r, len_acc_nxt;
  logic [dpd_pkg::SHIFT_W-1:0]        shift_r,   shift_nxt;
  logic [dpd_pkg::COUNT_W-1:0]        remain_r,  remain_nxt;
  logic [dpd_pkg::COUNT_W-1:0]        wptr_r,    wptr_nxt;
  logic [dpd_pkg::COUNT_W-1:0]        pos_r,     pos_nxt;
  logic [dpd_pkg::STATUS_W-1:0]       err_r,     err_nxt;

  logic [dpd_pkg::COUNT_W:0]          pos_after;
  logic                               at_end;
  logic                               more;
  logic [32:0]                        rgn_ext;
  logic [32:0]                        region_lim;
  logic                               shift_ok;
  logic [dpd_pkg::ACC_W-1:0]          shifted;
  logic [dpd_pkg::ACC_W-1:0]          acc_in;
  logic [dpd_pkg::ACC_W-1:0]          acc_new;
  logic [dpd_pkg::SHIFT_W-1:0]        shift_new;
  logic [32:0]                        end_sum;
  logic [32:0]                        need;
  logic                               range_bad;
  logic                               trunc_bad;
  logic [dpd_pkg::COUNT_W-1:0]        remain_dec;
  logic                               done;
  logic                               clear;

  // shared datapath terms
  always_comb begin
    pos_after  = {1'b0, pos_r} + 22'd1;
    at_end     = pos_after >= {1'b0, item.stream_bytes};
    more       = (item.patch_byte & dpd_pkg::VARINT_MORE) != 8'd0;
    rgn_ext    = {12'd0, region_bytes};
    region_lim = (rgn_ext > dpd_pkg::REGION_MAX_W) ? dpd_pkg::REGION_MAX_W : rgn_ext;
    shift_ok   = shift_r < dpd_pkg::VARINT_LIMIT;
    // shift is a multiple of seven below 32 here, so five bits suffice
    shifted    = {24'd0, item.patch_byte & dpd_pkg::VARINT_PAYLOAD} << shift_r[4:0];
    acc_in     = (phase_r == dpd_pkg::PH_OFFSET) ? off_acc_r : len_acc_r;
    acc_new    = shift_ok ? (acc_in | shifted) : acc_in;
    shift_new  = shift_ok ? (shift_r + dpd_pkg::VARINT_STEP) : shift_r;
    end_sum    = {1'b0, off_acc_r} + {1'b0, acc_new};
    need       = {11'd0, pos_after} + {1'b0, acc_new};
    range_bad  = end_sum > region_lim;
    trunc_bad  = need > {12'd0, item.stream_bytes};
    remain_dec = remain_r - 21'd1;
  end

  always_comb begin
    phase_nxt   = phase_r;
    off_acc_nxt = off_acc_r;
    len_acc_nxt = len_acc_r;
    shift_nxt   = shift_r;
    remain_nxt  = remain_r;
    wptr_nxt    = wptr_r;
    pos_nxt     = pos_r;
    err_nxt     = err_r;
    done        = 1'b0;
    clear       = 1'b0;
    result      = '0;

    if (err_r != dpd_pkg::ST_RUN) begin
      result.status = err_r;
    end else begin
      pos_nxt = pos_after[dpd_pkg::COUNT_W-1:0];
      case (phase_r)
        dpd_pkg::PH_OFFSET: begin
          off_acc_nxt = acc_new;
          shift_nxt   = shift_new;
          if (at_end) begin
            err_nxt = dpd_pkg::ST_TRUNC;
          end else if (!more) begin
            phase_nxt   = dpd_pkg::PH_LENGTH;
            len_acc_nxt = '0;
            shift_nxt   = '0;
          end
        end
        dpd_pkg::PH_LENGTH: begin
          len_acc_nxt = acc_new;
          shift_nxt   = shift_new;
          if (more) begin
            if (at_end) begin
              err_nxt = dpd_pkg::ST_TRUNC;
            end
          end else if (range_bad) begin
            err_nxt = dpd_pkg::ST_RANGE;
          end else if (trunc_bad) begin
            err_nxt = dpd_pkg::ST_TRUNC;
          end else if (acc_new == '0) begin
            if (at_end) begin
              done  = 1'b1;
              clear = 1'b1;
            end else begin
              phase_nxt   = dpd_pkg::PH_OFFSET;
              off_acc_nxt = '0;
              shift_nxt   = '0;
            end
          end else begin
            phase_nxt  = dpd_pkg::PH_DATA;
            remain_nxt = acc_new[dpd_pkg::COUNT_W-1:0];
            wptr_nxt   = off_acc_r[dpd_pkg::COUNT_W-1:0];
          end
        end
        default: begin
          // data byte: one write, address walks up
          result.write_enable  = 1'b1;
          result.write_address = wptr_r[dpd_pkg::ADDR_W-1:0];
          result.write_data    = item.patch_byte;
          wptr_nxt   = wptr_r + 21'd1;
          remain_nxt = remain_dec;
          if (remain_dec == '0) begin
            if (at_end) begin
              done  = 1'b1;
              clear = 1'b1;
            end else begin
              phase_nxt   = dpd_pkg::PH_OFFSET;
              off_acc_nxt = '0;
              shift_nxt   = '0;
            end
          end else if (at_end) begin
            err_nxt = dpd_pkg::ST_TRUNC;
          end
        end
      endcase

      if (clear) begin
        phase_nxt   = dpd_pkg::PH_OFFSET;
        off_acc_nxt = '0;
        len_acc_nxt = '0;
        shift_nxt   = '0;
        remain_nxt  = '0;
        wptr_nxt    = '0;
        pos_nxt     = '0;
      end

      if (err_nxt != dpd_pkg::ST_RUN) begin
        result.status = err_nxt;
      end else if (done) begin
        result.status = dpd_pkg::ST_DONE;
      end else begin
        result.status = dpd_pkg::ST_RUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= dpd_pkg::PH_OFFSET;
      off_acc_r <= '0;
      len_acc_r <= '0;
      shift_r   <= '0;
      remain_r  <= '0;
      wptr_r    <= '0;
      pos_r     <= '0;
      err_r     <= dpd_pkg::ST_RUN;
    end else if (step) begin
      phase_r   <= phase_nxt;
      off_acc_r <= off_acc_nxt;
      len_acc_r <= len_acc_nxt;
      shift_r   <= shift_nxt;
      remain_r  <= remain_nxt;
      wptr_r    <= wptr_nxt;
      pos_r     <= pos_nxt;
      err_r     <= err_nxt;
    end
  end

  assign stat.err      = err_r;
  assign stat.phase    = phase_r;
  assign stat.pos_zero = (pos_r == '0);

endmodule

// ----- hdl/dpd_out_reg.sv -----
// ----------------------------------------------------------------------------
// dpd_out_reg
// Result register stage; holds a result until the sink takes it.
// ----------------------------------------------------------------------------
module dpd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  dpd_pkg::result_t result,
  output logic             can_load,
  output logic             valid_r,
  output dpd_pkg::result_t result_r,
  input  logic             out_ready
);

  logic             valid_nxt;
  dpd_pkg::result_t result_nxt;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt  = valid_r;
    result_nxt = result_r;
    if (load) begin
      valid_nxt  = 1'b1;
      result_nxt = result;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    result_r <= result_nxt;
  end

endmodule

// ----- hdl/delta_patch_decoder.sv -----
// ----------------------------------------------------------------------------
// delta_patch_decoder
// Streaming varint offset/length delta patch decoder, one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                          sync
//  --------  ---------  -----------------------------------------------  ----------
//  in_ch     sink       patch_byte[8], stream_bytes[21]                  valid/ready
//  out_ch    source     write_enable, write_address[20], write_data[8],  valid/ready
//                       status[2]
//  cfg_*     write      cfg_wdata[21] = region_bytes on cfg_we           none
//
//  one byte transaction per clock sustained while out_ch is ready; each byte
//  yields exactly one result: input register, then parse step into result register
//  the parse step is a short varint shift-or plus a 33-bit add/compare pair
//  synchronous active-low reset; region_bytes resets to the full region size
//  a stalled sink holds the result register, and back-pressure reaches in_ch.ready
//  through the input register in the same cycle
//
module delta_patch_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [dpd_pkg::COUNT_W-1:0]  cfg_wdata,
  dpd_in_if.sink                       in_ch,
  dpd_out_if.source                    out_ch
);

  // region size register: the user writes it only while the decoder is idle; unchecked
  logic [dpd_pkg::COUNT_W-1:0] region_r, region_nxt;

  // input stage
  dpd_pkg::item_t       in_item;
  dpd_pkg::item_t       item_r;
  logic                 item_valid_r;

  // parse step and result stage
  logic                 step;
  logic                 can_load;
  dpd_pkg::result_t     step_result;
  dpd_pkg::result_t     result_r;
  logic                 result_valid_r;
  dpd_pkg::parse_stat_t stat;

  always_comb begin
    region_nxt = region_r;
    if (cfg_we) begin
      region_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r <= dpd_pkg::REGION_RESET;
    end else begin
      region_r <= region_nxt;
    end
  end

  assign in_item.patch_byte   = in_ch.patch_byte;
  assign in_item.stream_bytes = in_ch.stream_bytes;

  // a held byte moves through the parser whenever the result register can take it
  assign step = item_valid_r && can_load;

  dpd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_item  (in_item),
    .in_ready (in_ch.ready),
    .take     (can_load),
    .valid_r  (item_valid_r),
    .item_r   (item_r)
  );

  dpd_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .item         (item_r),
    .region_bytes (region_r),
    .result       (step_result),
    .stat         (stat)
  );

  dpd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .result    (step_result),
    .can_load  (can_load),
    .valid_r   (result_valid_r),
    .result_r  (result_r),
    .out_ready (out_ch.ready)
  );

  assign out_ch.valid         = result_valid_r;
  assign out_ch.write_enable  = result_r.write_enable;
  assign out_ch.write_address = result_r.write_address;
  assign out_ch.write_data    = result_r.write_data;
  assign out_ch.status        = result_r.status;

  // an error, once raised, never changes until reset
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.err != dpd_pkg::ST_RUN) |=> (stat.err == $past(stat.err)))
    else $error("sticky error changed");

  // with an error standing, each byte reports it and writes nothing
  a_err_report: assert property (@(posedge clk) disable iff (!rst_n)
    (step && stat.err != dpd_pkg::ST_RUN) |=>
      (out_ch.valid && !out_ch.write_enable && out_ch.status == $past(stat.err)))
    else $error("error byte result wrong");

  // a finished stream leaves the parser in its reset state
  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step && step_result.status == dpd_pkg::ST_DONE) |=>
      (stat.phase == dpd_pkg::PH_OFFSET && stat.pos_zero))
    else $error("parser not cleared after stream end");

  // writes come only from the data phase
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (step && step_result.write_enable) |-> (stat.phase == dpd_pkg::PH_DATA))
    else $error("write outside data phase");

endmodule

// ----- verif/delta_patch_decoder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delta_patch_decoder_tb
// Self-checking bench for the delta patch decoder. A directed table covers
// reset, the address extremes, long and padded varints, a zero length entry
// and a wide stream tag. Random well-formed patch streams then run under
// several region sizes, with random gaps on both channels. Every result
// transaction is compared field by field against its hand-written expectation or
// a cycle-free decoder model kept in the bench. One broken stream closes
// the run, since errors are sticky until reset.
// ----------------------------------------------------------------------------
module delta_patch_decoder_tb;
  import dpd_pkg::*;

  // one row of patch input, with an optional hand-written expectation
  typedef struct {
    item_t   it;
    bit      fixed;
    result_t exp;
  } stim_t;

  // ways the closing stream is broken
  typedef enum int {
    BRK_REGION,
    BRK_WIDE_SUM,
    BRK_PAST_END,
    BRK_IN_OFFSET,
    BRK_IN_LENGTH,
    BRK_IN_DATA
  } break_kind_t;

  localparam int unsigned ITEMS_PER_PHASE = 236;
  localparam int unsigned DRAIN_GUARD     = 5000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [COUNT_W-1:0]   cfg_wdata = '0;
  logic                 sink_ready = 1'b0;
  int                   sink_hold = 0;

  dpd_in_if  patch_ch ();
  dpd_out_if write_ch ();

  assign write_ch.ready = sink_ready;

  delta_patch_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (patch_ch),
    .out_ch    (write_ch)
  );

  // decoder model state, mirrors the block after reset
  logic [COUNT_W-1:0]  region_cfg = REGION_RESET;
  logic [1:0]          parse_ph   = PH_OFFSET;
  logic [ACC_W-1:0]    off_acc    = '0;
  logic [ACC_W-1:0]    len_acc    = '0;
  logic [SHIFT_W-1:0]  vshift     = '0;
  logic [COUNT_W-1:0]  owed       = '0;
  logic [COUNT_W-1:0]  wptr       = '0;
  logic [COUNT_W-1:0]  spos       = '0;
  logic [STATUS_W-1:0] err_latch  = ST_RUN;  // ST_RUN doubles as no error

  result_t pending_writes[$];   // expected result transactions, oldest first
  stim_t   directed_rows[$];
  int      mismatches = 0;
  int      sent_bytes = 0;
  bit      calm_link  = 1'b0;   // no gaps on either side while set

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // decoder model
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] region_limit();
    // sizes above the largest region are clamped
    if (64'(region_cfg) > 64'(REGION_MAX_BYTES)) return 64'(REGION_MAX_BYTES);
    return 64'(region_cfg);
  endfunction

  // back to the start of a stream, error latch untouched
  task automatic clear_parse();
    parse_ph = PH_OFFSET;
    off_acc  = '0;
    len_acc  = '0;
    vshift   = '0;
    owed     = '0;
    wptr     = '0;
    spos     = '0;
  endtask

  // base-128 accumulate; payload past bit 31 is dropped, shift parks at 35
  task automatic gather_varint(inout logic [ACC_W-1:0] acc, input logic [BYTE_W-1:0] b);
    if (vshift < VARINT_LIMIT) begin
      acc    = acc | (32'(b & VARINT_PAYLOAD) << vshift);
      vshift = vshift + VARINT_STEP;
    end
  endtask

  task automatic decode_patch_byte(input item_t it, output result_t r);
    logic [63:0] pos_next;
    logic [63:0] tot;
    logic        at_end;
    logic        more;
    r        = '0;
    r.status = ST_RUN;
    if (err_latch != ST_RUN) begin
      // sticky error: nothing written, error repeated
      r.status = err_latch;
    end else begin
      pos_next = 64'(spos) + 64'd1;
      tot      = 64'(it.stream_bytes);
      at_end   = (pos_next >= tot);
      more     = ((it.patch_byte & VARINT_MORE) != '0);
      spos     = pos_next[COUNT_W-1:0];
      case (parse_ph)
        PH_OFFSET: begin
          gather_varint(off_acc, it.patch_byte);
          if (at_end) begin
            // stream ends inside or right after the offset varint
            err_latch = ST_TRUNC;
          end else if (!more) begin
            parse_ph = PH_LENGTH;
            len_acc  = '0;
            vshift   = '0;
          end
        end
        PH_LENGTH: begin
          gather_varint(len_acc, it.patch_byte);
          if (more) begin
            if (at_end) err_latch = ST_TRUNC;
          end else if (64'(off_acc) + 64'(len_acc) > region_limit()) begin
            // wide sum, no 32-bit wrap
            err_latch = ST_RANGE;
          end else if (pos_next + 64'(len_acc) > tot) begin
            err_latch = ST_TRUNC;
          end else if (len_acc == '0) begin
            // zero length entry, no writes
            if (at_end) begin
              r.status = ST_DONE;
              clear_parse();
            end else begin
              parse_ph = PH_OFFSET;
              off_acc  = '0;
              vshift   = '0;
            end
          end else begin
            parse_ph = PH_DATA;
            owed     = len_acc[COUNT_W-1:0];
            wptr     = off_acc[COUNT_W-1:0];
          end
        end
        default: begin
          r.write_enable  = 1'b1;
          r.write_address = wptr[ADDR_W-1:0];
          r.write_data    = it.patch_byte;
          wptr            = wptr + 1'b1;
          owed            = owed - 1'b1;
          if (owed == '0) begin
            if (at_end) begin
              r.status = ST_DONE;
              clear_parse();
            end else begin
              parse_ph = PH_OFFSET;
              off_acc  = '0;
              vshift   = '0;
            end
          end else if (at_end) begin
            // stream tag moved so that data is still owed
            err_latch = ST_TRUNC;
          end
        end
      endcase
      if (err_latch != ST_RUN) r.status = err_latch;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic stim_t row(logic [BYTE_W-1:0] b, logic [COUNT_W-1:0] tag,
                                bit fixed = 1'b0, logic we = 1'b0,
                                logic [ADDR_W-1:0] addr = '0,
                                logic [BYTE_W-1:0] d = '0,
                                logic [STATUS_W-1:0] st = ST_RUN);
    stim_t s;
    s.it.patch_byte       = b;
    s.it.stream_bytes     = tag;
    s.fixed               = fixed;
    s.exp.write_enable    = we;
    s.exp.write_address   = addr;
    s.exp.write_data      = d;
    s.exp.status          = st;
    return s;
  endfunction

  // one patch byte transaction; the model runs at the accepting edge
  task automatic push_byte(input stim_t s);
    int      gap;
    result_t pred;
    gap = calm_link ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      patch_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    patch_ch.valid        <= 1'b1;
    patch_ch.patch_byte   <= s.it.patch_byte;
    patch_ch.stream_bytes <= s.it.stream_bytes;
    do @(posedge clk); while (!patch_ch.ready);
    decode_patch_byte(s.it, pred);
    pending_writes.push_back(s.fixed ? s.exp : pred);
    sent_bytes++;
  endtask

  // stop sending and wait for every expected result
  task automatic wait_writes_drained();
    int guard;
    guard = 0;
    patch_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending_writes.size() != 0 && guard < DRAIN_GUARD);
  endtask

  // register write while idle
  task automatic set_region(input logic [COUNT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    region_cfg = v;
    cfg_we    <= 1'b0;
  endtask

  // varint encoder; pad adds non-minimal bytes, negative pad picks at random
  task automatic put_varint(ref logic [BYTE_W-1:0] q[$], input logic [ACC_W-1:0] v,
                            input int pad);
    int         n;
    int         cnt;
    logic [6:0] p;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != '0) n++;
    if (pad < 0) pad = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
    cnt = n + pad;
    for (int i = 0; i < cnt; i++) begin
      if (i < 4) p = 7'(v >> (7 * i));
      else if (i == 4) p = {3'($urandom_range(0, 7)), v[31:28]};  // top bits dropped
      else p = 7'($urandom_range(0, 127));                         // past the shift limit
      q.push_back({i != cnt - 1, p});
    end
  endtask

  task automatic put_entry(ref logic [BYTE_W-1:0] q[$], input logic [ACC_W-1:0] off,
                           input logic [ACC_W-1:0] len);
    put_varint(q, off, -1);
    put_varint(q, len, -1);
    repeat (len) q.push_back(8'($urandom_range(0, 255)));
  endtask

  // well-formed stream of 1 to 4 entries inside the current region
  task automatic send_stream();
    logic [BYTE_W-1:0]  pb[$];
    logic [COUNT_W-1:0] last_tag;
    logic [COUNT_W-1:0] body_tag;
    logic [63:0]        lim;
    logic [ACC_W-1:0]   len;
    logic [ACC_W-1:0]   off;
    int                 pick;
    lim = region_limit();
    repeat ($urandom_range(1, 4)) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) len = $urandom_range(0, 6);
      else if (pick < 19) len = $urandom_range(7, 24);
      else len = $urandom_range(25, 64);
      if (64'(len) > lim) len = lim[31:0];
      pick = $urandom_range(0, 7);
      if (pick == 0) off = '0;
      else if (pick < 3) off = lim[31:0] - len;          // ends exactly at region top
      else off = $urandom_range(0, lim[31:0] - len);
      put_entry(pb, off, len);
    end
    last_tag = COUNT_W'(pb.size());
    body_tag = last_tag;
    // some streams carry a wide tag that drops to the true length on the last byte
    if ($urandom_range(0, 6) == 0)
      body_tag = ($urandom_range(0, 3) == 0) ? REGION_RESET
                                             : COUNT_W'($urandom_range(last_tag, REGION_RESET));
    for (int i = 0; i < pb.size(); i++)
      push_byte(row(pb[i], (i == pb.size() - 1) ? last_tag : body_tag));
  endtask

  // one broken stream, then noise to check the sticky error
  task automatic send_broken_stream();
    logic [BYTE_W-1:0]  pb[$];
    logic [COUNT_W-1:0] tg[$];
    logic [63:0]        lim;
    logic [ACC_W-1:0]   off;
    logic [ACC_W-1:0]   len;
    int                 hdr_off;
    int                 hdr;
    int                 n;
    int                 cut;
    break_kind_t        kind;
    lim  = region_limit();
    kind = break_kind_t'($urandom_range(0, 5));
    len  = $urandom_range(2, 8);
    off  = (lim >= 64'(len)) ? $urandom_range(0, lim[31:0] - len) : '0;
    if (kind == BRK_REGION) off = lim[31:0] - len + 1 + $urandom_range(0, 3);
    if (kind == BRK_WIDE_SUM) off = 32'hFFFF_FFFF - $urandom_range(0, 1);
    put_varint(pb, off, -1);
    hdr_off = pb.size();
    put_varint(pb, len, (kind == BRK_IN_LENGTH) ? $urandom_range(1, 3) : -1);
    hdr = pb.size();
    repeat (len) pb.push_back(8'($urandom_range(0, 255)));
    n   = pb.size();
    cut = n;
    case (kind)
      BRK_PAST_END: begin
        // entry reaches past the stream end
        repeat (n) tg.push_back(COUNT_W'(n - $urandom_range(1, len)));
      end
      BRK_IN_OFFSET: begin
        cut = $urandom_range(1, hdr_off);
        repeat (n) tg.push_back(COUNT_W'(cut));
      end
      BRK_IN_LENGTH: begin
        cut = $urandom_range(hdr_off + 1, hdr);
        repeat (n) tg.push_back(COUNT_W'(cut));
      end
      BRK_IN_DATA: begin
        cut = $urandom_range(hdr + 1, n - 1);
        repeat (n) tg.push_back(COUNT_W'(n));
        tg[cut - 1] = COUNT_W'(cut);
      end
      default: begin
        repeat (n) tg.push_back(COUNT_W'(n));
      end
    endcase
    for (int i = 0; i < cut; i++) push_byte(row(pb[i], tg[i]));
    repeat ($urandom_range(4, 12))
      push_byte(row(8'($urandom_range(0, 255)),
                    COUNT_W'($urandom_range(1, REGION_MAX_BYTES))));
  endtask

  // ---------------------------------------------------------------------------
  // result sink: random stalls, field by field compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    int      hold;
    if (!rst_n) begin
      sink_ready <= 1'b0;
      sink_hold  <= 0;
    end else begin
      if (write_ch.valid && sink_ready) begin
        if (pending_writes.size() == 0) begin
          $error("result transaction with no expected write pending");
          mismatches++;
        end else begin
          want = pending_writes.pop_front();
          if (write_ch.write_enable !== want.write_enable) begin
            $error("write_enable expected %0h got %0h", want.write_enable,
                   write_ch.write_enable);
            mismatches++;
          end
          if (write_ch.write_address !== want.write_address) begin
            $error("write_address expected %0h got %0h", want.write_address,
                   write_ch.write_address);
            mismatches++;
          end
          if (write_ch.write_data !== want.write_data) begin
            $error("write_data expected %0h got %0h", want.write_data, write_ch.write_data);
            mismatches++;
          end
          if (write_ch.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, write_ch.status);
            mismatches++;
          end
        end
        hold = calm_link ? 0 : $urandom_range(0, 9);
        sink_hold  <= hold;
        sink_ready <= (hold == 0);
      end else if (sink_hold > 1) begin
        sink_hold <= sink_hold - 1;
      end else begin
        sink_hold  <= 0;
        sink_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [COUNT_W-1:0] plan[7];
    int                 phase_end;
    patch_ch.valid        = 1'b0;
    patch_ch.patch_byte   = '0;
    patch_ch.stream_bytes = '0;

    // directed table; rows with fixed results are obvious from the stream layout
    // smallest entry: offset 0, one byte of data
    directed_rows.push_back(row(8'h00, 21'd3, 1'b1));
    directed_rows.push_back(row(8'h01, 21'd3, 1'b1));
    directed_rows.push_back(row(8'hFF, 21'd3, 1'b1, 1'b1, 20'h00000, 8'hFF, ST_DONE));
    // top address of the region
    directed_rows.push_back(row(8'hFF, 21'd5, 1'b1));
    directed_rows.push_back(row(8'hFF, 21'd5, 1'b1));
    directed_rows.push_back(row(8'h3F, 21'd5, 1'b1));
    directed_rows.push_back(row(8'h01, 21'd5, 1'b1));
    directed_rows.push_back(row(8'h00, 21'd5, 1'b1, 1'b1, 20'hFFFFF, 8'h00, ST_DONE));
    // long offset varint with dropped bits, padded length, then a zero length entry
    directed_rows.push_back(row(8'h85, 21'd12));
    directed_rows.push_back(row(8'h80, 21'd12));
    directed_rows.push_back(row(8'h80, 21'd12));
    directed_rows.push_back(row(8'h80, 21'd12));
    directed_rows.push_back(row(8'hF0, 21'd12));
    directed_rows.push_back(row(8'h7F, 21'd12));
    directed_rows.push_back(row(8'h82, 21'd12));
    directed_rows.push_back(row(8'h00, 21'd12));
    directed_rows.push_back(row(8'hAA, 21'd12));
    directed_rows.push_back(row(8'h55, 21'd12));
    directed_rows.push_back(row(8'h00, 21'd12));
    directed_rows.push_back(row(8'h00, 21'd12));
    // offset equal to the full region, zero length, widest tag
    directed_rows.push_back(row(8'h80, REGION_RESET, 1'b1));
    directed_rows.push_back(row(8'h80, REGION_RESET, 1'b1));
    directed_rows.push_back(row(8'h40, REGION_RESET, 1'b1));
    directed_rows.push_back(row(8'h00, 21'd4, 1'b1, 1'b0, 20'h00000, 8'h00, ST_DONE));

    // region sizes per random phase, extremes included
    plan[0] = COUNT_W'($urandom_range(257, REGION_MAX_BYTES - 1));
    plan[1] = '0;
    plan[2] = 21'd1;
    plan[3] = 21'h1FFFFF;                 // above the largest region, clamped
    plan[4] = COUNT_W'($urandom_range(256, 4096));
    plan[5] = 21'h0FFFFF;
    plan[6] = REGION_RESET;

    // synchronous reset held asserted from time zero, then released
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at the reset region size
    foreach (directed_rows[i]) push_byte(directed_rows[i]);
    wait_writes_drained();

    // random well-formed streams, one phase per region size
    phase_end = sent_bytes;
    foreach (plan[p]) begin
      wait_writes_drained();
      set_region(plan[p]);
      phase_end += ITEMS_PER_PHASE;
      while (sent_bytes < phase_end) begin
        calm_link = ($urandom_range(0, 4) == 0);
        // now and then let the pipe run dry mid phase
        if ($urandom_range(0, 24) == 0) wait_writes_drained();
        send_stream();
      end
    end

    // the error latches until reset, so the broken stream comes last
    calm_link = 1'b0;
    send_broken_stream();

    wait_writes_drained();
    // keep the clock running to catch stray results
    repeat (8) @(posedge clk);
    if (pending_writes.size() != 0) begin
      $error("%0d expected writes never arrived", pending_writes.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
